FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PDVCU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define PDVCU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pdvcu_pkg.sv
`default_nettype none

package pdvcu_pkg;

   // values carried per grid point
   localparam int NVALS = 11;

   // value slots inside one point
   localparam int P_XA  = 0;
   localparam int P_XV0 = 1;
   localparam int P_XV1 = 2;
   localparam int P_YA  = 3;
   localparam int P_YV0 = 4;
   localparam int P_YV1 = 5;
   localparam int P_VOL = 6;
   localparam int P_PRE = 7;
   localparam int P_RHO = 8;
   localparam int P_VIS = 9;
   localparam int P_EN  = 10;

   // register indexes
   localparam logic [1:0] CSR_TIME_STEP  = 2'd0;
   localparam logic [1:0] CSR_PREDICT    = 2'd1;
   localparam logic [1:0] CSR_ROW_POINTS = 2'd2;

   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

   typedef logic [NVALS-1:0][63:0] vals_type;

   typedef struct packed {
      logic               frame_start;
      logic signed [63:0] x_face_area;
      logic signed [63:0] x_vel_old;
      logic signed [63:0] x_vel_new;
      logic signed [63:0] y_face_area;
      logic signed [63:0] y_vel_old;
      logic signed [63:0] y_vel_new;
      logic signed [63:0] cell_volume;
      logic signed [63:0] cell_pressure;
      logic signed [63:0] density_old;
      logic signed [63:0] cell_viscosity;
      logic signed [63:0] energy_old;
   } pdvcu_req_type;

   typedef struct packed {
      logic signed [63:0] volume_ratio;
      logic signed [63:0] density_new;
      logic signed [63:0] energy_new;
   } pdvcu_rsp_type;

   // request to a shared arithmetic unit
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } op_req_type;

   // answer of a shared arithmetic unit
   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } op_rsp_type;

   // saturating add
   function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if (((a ^ r) & (b ^ r)) >> 63 != 64'd0) begin
         r = a[63] ? SMIN : SMAX;
      end
      return r;
   endfunction

   // saturating subtract
   function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a - b;
      if (((a ^ b) & (a ^ r)) >> 63 != 64'd0) begin
         r = a[63] ? SMIN : SMAX;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pdv_cell_update_core.sv
// Compression work update over a raster stream of grid points.
// req_*: one grid point per transaction (valid/ready). Points arrive in raster
//    order; frame_start restarts the scan. The previous row sits in a line
//    memory of MAX_ROW_POINTS entries, the left and diagonal points in regs.
// rsp_*: one transaction per cell, issued when its top-right point arrives;
//    points of the first row and first column give no result.
// csr_*: write-only registers (time step, predict mode, row length); the user
//    writes them while the block is idle, which the block does not enforce.
// Throughput: one point at a time. A point with no result frees the input
//    right after its line memory read. A point with a result makes four
//    passes of the shared bit-serial divider plus eleven passes of the shared
//    multiplier, which sums four partial products.
// Stall: a finished result waits in the output register; the next point is
//    accepted meanwhile, and only its own result waits for the slot.
// Reset: clears the configuration, scan position, stencil and control registers;
//    the datapath registers and the line memory are not cleared (every column is written in the first row).
`default_nettype none

module pdv_cell_update_core #(
   parameter int MAX_ROW_POINTS = 1025,
   parameter int FRAC_BITS      = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pdvcu_pkg::pdvcu_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pdvcu_pkg::pdvcu_rsp_type rsp_data,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [63:0]              csr_wdata
);

   localparam int CW = $clog2(MAX_ROW_POINTS + 1);
   localparam int AW = $clog2(MAX_ROW_POINTS);
   localparam int LW = (CW > 11) ? CW : 11;
   localparam int RW = pdvcu_pkg::NVALS * 64;

   localparam logic [1:0] FACE_RIGHT  = 2'd0;
   localparam logic [1:0] FACE_LEFT   = 2'd1;
   localparam logic [1:0] FACE_TOP    = 2'd2;
   localparam logic [1:0] FACE_BOTTOM = 2'd3;

   localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_READ     = 14'b00000000000010,
      ST_SUM      = 14'b00000000000100,
      ST_MUL_AREA = 14'b00000000001000,
      ST_MUL_STEP = 14'b00000000010000,
      ST_ACC      = 14'b00000000100000,
      ST_DIV_VR   = 14'b00000001000000,
      ST_DIV_RCP  = 14'b00000010000000,
      ST_DIV_PRE  = 14'b00000100000000,
      ST_DIV_VIS  = 14'b00001000000000,
      ST_MUL_EC   = 14'b00010000000000,
      ST_MUL_RCP  = 14'b00100000000000,
      ST_MUL_RHO  = 14'b01000000000000,
      ST_OUT      = 14'b10000000000000
   } state_type;

   // configuration
   logic [62:0] ts_ff;
   logic        predict_ff;
   logic [10:0] rowpts_ff;

   // control state
   state_type   state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic        first_ff, first_in;
   logic [CW-1:0] item_col_ff, item_col_in;
   logic        item_first_ff, item_first_in;
   logic [1:0]  face_ff, face_in;
   logic [1:0]  sub_ff, sub_in;
   logic        pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pdvcu_pkg::vals_type left_ff, left_in;
   pdvcu_pkg::vals_type diag_ff, diag_in;

   // datapath
   pdvcu_pkg::vals_type cur_ff, cur_in;
   pdvcu_pkg::vals_type above_ff, above_in;
   logic [63:0] sum_ff, sum_in;
   logic [63:0] flux_ff, flux_in;
   logic [63:0] tot_ff, tot_in;
   logic [63:0] vr_ff, vr_in;
   logic [63:0] rcp_ff, rcp_in;
   logic [63:0] ec_ff, ec_in;
   logic [63:0] dens_ff, dens_in;
   pdvcu_pkg::pdvcu_rsp_type rsp_data_ff, rsp_data_in;

   // misc
   logic          accept;
   logic [LW-1:0] rp_ext, len;
   logic [CW-1:0] acc_col, acc_col_nx;
   logic          acc_first;
   pdvcu_pkg::vals_type cur_vals;
   logic [RW-1:0] ram_rdata;
   logic [63:0]   f_area, f_o1, f_o2, f_n1, f_n2;
   logic          is_mul, is_div, op_done;
   logic [63:0]   op_res;
   pdvcu_pkg::op_req_type mul_req, div_req;
   pdvcu_pkg::op_rsp_type mul_rsp, div_rsp;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff      <= '0;
         predict_ff <= 1'b0;
         rowpts_ff  <= 11'd1025;
      end else if (csr_we) begin
         unique case (csr_index)
            pdvcu_pkg::CSR_TIME_STEP:  ts_ff      <= csr_wdata[62:0];
            pdvcu_pkg::CSR_PREDICT:    predict_ff <= csr_wdata[0];
            pdvcu_pkg::CSR_ROW_POINTS: rowpts_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // effective row length
   always_comb begin
      rp_ext = LW'(rowpts_ff);
      if (rp_ext < LW'(2)) begin
         len = LW'(2);
      end else if (rp_ext > LW'(MAX_ROW_POINTS)) begin
         len = LW'(MAX_ROW_POINTS);
      end else begin
         len = rp_ext;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // column of the incoming point
   always_comb begin
      acc_col   = req_data.frame_start ? '0 : col_ff;
      acc_first = req_data.frame_start ? 1'b1 : first_ff;
      if (LW'(acc_col) >= len) begin
         acc_col   = '0;
         acc_first = 1'b0;
      end
      acc_col_nx = acc_col + CW'(1);
   end

   // incoming point as a value vector
   always_comb begin
      cur_vals[pdvcu_pkg::P_XA]  = req_data.x_face_area;
      cur_vals[pdvcu_pkg::P_XV0] = req_data.x_vel_old;
      cur_vals[pdvcu_pkg::P_XV1] = req_data.x_vel_new;
      cur_vals[pdvcu_pkg::P_YA]  = req_data.y_face_area;
      cur_vals[pdvcu_pkg::P_YV0] = req_data.y_vel_old;
      cur_vals[pdvcu_pkg::P_YV1] = req_data.y_vel_new;
      cur_vals[pdvcu_pkg::P_VOL] = req_data.cell_volume;
      cur_vals[pdvcu_pkg::P_PRE] = req_data.cell_pressure;
      cur_vals[pdvcu_pkg::P_RHO] = req_data.density_old;
      cur_vals[pdvcu_pkg::P_VIS] = req_data.cell_viscosity;
      cur_vals[pdvcu_pkg::P_EN]  = req_data.energy_old;
   end

   // previous row line memory
   pdvcu_ram #(
      .WIDTH(RW),
      .DEPTH(MAX_ROW_POINTS)
   ) u_line (
      .clock(clock),
      .we   (state_ff == ST_READ),
      .waddr(item_col_ff[AW-1:0]),
      .wdata(cur_ff),
      .re   (accept),
      .raddr(acc_col[AW-1:0]),
      .rdata(ram_rdata)
   );

   // face operand selection
   always_comb begin
      case (face_ff)
         FACE_RIGHT: begin
            f_area = above_ff[pdvcu_pkg::P_XA];
            f_o1   = above_ff[pdvcu_pkg::P_XV0];
            f_o2   = cur_ff[pdvcu_pkg::P_XV0];
            f_n1   = above_ff[pdvcu_pkg::P_XV1];
            f_n2   = cur_ff[pdvcu_pkg::P_XV1];
         end
         FACE_LEFT: begin
            f_area = diag_ff[pdvcu_pkg::P_XA];
            f_o1   = diag_ff[pdvcu_pkg::P_XV0];
            f_o2   = left_ff[pdvcu_pkg::P_XV0];
            f_n1   = diag_ff[pdvcu_pkg::P_XV1];
            f_n2   = left_ff[pdvcu_pkg::P_XV1];
         end
         FACE_TOP: begin
            f_area = left_ff[pdvcu_pkg::P_YA];
            f_o1   = left_ff[pdvcu_pkg::P_YV0];
            f_o2   = cur_ff[pdvcu_pkg::P_YV0];
            f_n1   = left_ff[pdvcu_pkg::P_YV1];
            f_n2   = cur_ff[pdvcu_pkg::P_YV1];
         end
         default: begin
            f_area = diag_ff[pdvcu_pkg::P_YA];
            f_o1   = diag_ff[pdvcu_pkg::P_YV0];
            f_o2   = above_ff[pdvcu_pkg::P_YV0];
            f_n1   = diag_ff[pdvcu_pkg::P_YV1];
            f_n2   = above_ff[pdvcu_pkg::P_YV1];
         end
      endcase
      // predictor uses the old velocities twice
      if (predict_ff) begin
         f_n1 = f_o1;
         f_n2 = f_o2;
      end
   end

   // shared unit operands
   assign is_mul = (state_ff == ST_MUL_AREA) || (state_ff == ST_MUL_STEP) ||
                   (state_ff == ST_MUL_EC) || (state_ff == ST_MUL_RCP) ||
                   (state_ff == ST_MUL_RHO);
   assign is_div = (state_ff == ST_DIV_VR) || (state_ff == ST_DIV_RCP) ||
                   (state_ff == ST_DIV_PRE) || (state_ff == ST_DIV_VIS);

   always_comb begin
      mul_req.start = is_mul && !pend_ff;
      div_req.start = is_div && !pend_ff;
      mul_req.a = 64'd0;
      mul_req.b = 64'd0;
      div_req.a = 64'd0;
      div_req.b = 64'd0;
      case (state_ff)
         ST_MUL_AREA: begin
            mul_req.a = f_area;
            mul_req.b = sum_ff;
         end
         ST_MUL_STEP: begin
            mul_req.a = flux_ff;
            mul_req.b = {1'b0, ts_ff};
         end
         ST_MUL_EC: begin
            mul_req.a = ec_ff;
            mul_req.b = tot_ff;
         end
         ST_MUL_RCP: begin
            mul_req.a = ec_ff;
            mul_req.b = rcp_ff;
         end
         ST_MUL_RHO: begin
            mul_req.a = diag_ff[pdvcu_pkg::P_RHO];
            mul_req.b = vr_ff;
         end
         ST_DIV_VR: begin
            div_req.a = diag_ff[pdvcu_pkg::P_VOL];
            div_req.b = pdvcu_pkg::sadd(diag_ff[pdvcu_pkg::P_VOL], tot_ff);
         end
         ST_DIV_RCP: begin
            div_req.a = ONE;
            div_req.b = diag_ff[pdvcu_pkg::P_VOL];
         end
         ST_DIV_PRE: begin
            div_req.a = diag_ff[pdvcu_pkg::P_PRE];
            div_req.b = diag_ff[pdvcu_pkg::P_RHO];
         end
         ST_DIV_VIS: begin
            div_req.a = diag_ff[pdvcu_pkg::P_VIS];
            div_req.b = diag_ff[pdvcu_pkg::P_RHO];
         end
         default: ;
      endcase
   end

   pdvcu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock),
      .reset(reset),
      .req  (mul_req),
      .rsp  (mul_rsp)
   );

   pdvcu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   assign op_done = is_mul ? mul_rsp.done : div_rsp.done;
   assign op_res  = is_mul ? mul_rsp.result : div_rsp.result;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      first_in      = first_ff;
      item_col_in   = item_col_ff;
      item_first_in = item_first_ff;
      face_in       = face_ff;
      sub_in        = sub_ff;
      pend_in       = pend_ff;
      left_in       = left_ff;
      diag_in       = diag_ff;
      cur_in        = cur_ff;
      above_in      = above_ff;
      sum_in        = sum_ff;
      flux_in       = flux_ff;
      tot_in        = tot_ff;
      vr_in         = vr_ff;
      rcp_in        = rcp_ff;
      ec_in         = ec_ff;
      dens_in       = dens_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (is_mul || is_div) begin
         if (!pend_ff) begin
            pend_in = 1'b1;
         end else if (op_done) begin
            pend_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in      = ST_READ;
               item_col_in   = acc_col;
               item_first_in = acc_first;
               cur_in        = cur_vals;
               if (LW'(acc_col_nx) >= len) begin
                  col_in   = '0;
                  first_in = 1'b0;
               end else begin
                  col_in   = acc_col_nx;
                  first_in = acc_first;
               end
            end
         end
         ST_READ: begin
            above_in = item_first_ff ? '0 : ram_rdata;
            if (item_first_ff || item_col_ff == '0) begin
               diag_in  = item_first_ff ? '0 : ram_rdata;
               left_in  = cur_ff;
               state_in = ST_IDLE;
            end else begin
               face_in  = FACE_RIGHT;
               sub_in   = 2'd0;
               tot_in   = 64'd0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // one saturating add per cycle, in model order
            case (sub_ff)
               2'd0:    sum_in = pdvcu_pkg::sadd(f_o1, f_o2);
               2'd1:    sum_in = pdvcu_pkg::sadd(sum_ff, f_n1);
               default: sum_in = pdvcu_pkg::sadd(sum_ff, f_n2);
            endcase
            if (sub_ff == 2'd2) begin
               sub_in   = 2'd0;
               state_in = ST_MUL_AREA;
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
         ST_MUL_AREA: begin
            if (pend_ff && op_done) begin
               flux_in  = {{2{op_res[63]}}, op_res[63:2]};
               state_in = ST_MUL_STEP;
            end
         end
         ST_MUL_STEP: begin
            if (pend_ff && op_done) begin
               flux_in  = predict_ff ? {op_res[63], op_res[63:1]} : op_res;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            // total = right - left + top - bottom
            case (face_ff)
               FACE_RIGHT: tot_in = flux_ff;
               FACE_TOP:   tot_in = pdvcu_pkg::sadd(tot_ff, flux_ff);
               default:    tot_in = pdvcu_pkg::ssub(tot_ff, flux_ff);
            endcase
            if (face_ff == FACE_BOTTOM) begin
               state_in = ST_DIV_VR;
            end else begin
               face_in  = face_ff + 2'd1;
               state_in = ST_SUM;
            end
         end
         ST_DIV_VR: begin
            if (pend_ff && op_done) begin
               vr_in    = op_res;
               state_in = ST_DIV_RCP;
            end
         end
         ST_DIV_RCP: begin
            if (pend_ff && op_done) begin
               rcp_in   = op_res;
               state_in = ST_DIV_PRE;
            end
         end
         ST_DIV_PRE: begin
            if (pend_ff && op_done) begin
               ec_in    = op_res;
               state_in = ST_DIV_VIS;
            end
         end
         ST_DIV_VIS: begin
            if (pend_ff && op_done) begin
               ec_in    = pdvcu_pkg::sadd(ec_ff, op_res);
               state_in = ST_MUL_EC;
            end
         end
         ST_MUL_EC: begin
            if (pend_ff && op_done) begin
               ec_in    = op_res;
               state_in = ST_MUL_RCP;
            end
         end
         ST_MUL_RCP: begin
            if (pend_ff && op_done) begin
               ec_in    = op_res;
               state_in = ST_MUL_RHO;
            end
         end
         ST_MUL_RHO: begin
            if (pend_ff && op_done) begin
               dens_in  = op_res;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // load the output slot once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.volume_ratio = vr_ff;
               rsp_data_in.density_new  = dens_ff;
               rsp_data_in.energy_new   =
                  pdvcu_pkg::ssub(diag_ff[pdvcu_pkg::P_EN], ec_ff);
               rsp_valid_in = 1'b1;
               diag_in      = above_ff;
               left_in      = cur_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         first_ff      <= 1'b1;
         item_col_ff   <= '0;
         item_first_ff <= 1'b1;
         face_ff       <= FACE_RIGHT;
         sub_ff        <= 2'd0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         left_ff       <= '0;
         diag_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         first_ff      <= first_in;
         item_col_ff   <= item_col_in;
         item_first_ff <= item_first_in;
         face_ff       <= face_in;
         sub_ff        <= sub_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         left_ff       <= left_in;
         diag_ff       <= diag_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      above_ff    <= above_in;
      sum_ff      <= sum_in;
      flux_ff     <= flux_in;
      tot_ff      <= tot_in;
      vr_ff       <= vr_in;
      rcp_ff      <= rcp_in;
      ec_ff       <= ec_in;
      dens_ff     <= dens_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/pdvcu_ram.sv
`default_nettype none

module pdvcu_ram #(
   parameter int WIDTH = 704,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pdvcu_mul.sv
`default_nettype none

module pdvcu_mul #(
   parameter int FRAC_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pdvcu_pkg::op_req_type req,
   output pdvcu_pkg::op_rsp_type rsp
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [2:0]   phase_ff, phase_in;
   logic [63:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic         neg_ff, neg_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  res_ff, res_in;
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] pp_ext;
   logic [64-FRAC_BITS:0] top_bits;
   logic         fits;

   // partial product of the current phase
   assign a_half = phase_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign b_half = phase_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign pp     = a_half * b_half;

   always_comb begin
      case (phase_ff[1:0])
         2'd0:    pp_ext = {64'd0, pp};
         2'd3:    pp_ext = {pp, 64'd0};
         default: pp_ext = {32'd0, pp, 32'd0};
      endcase
   end

   // bits above the result must all match its sign
   assign top_bits = acc_ff[127:FRAC_BITS+63];
   assign fits     = (&top_bits) || !(|top_bits);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         phase_in = 3'd0;
         ma_in    = req.a[63] ? 64'd0 - req.a : req.a;
         mb_in    = req.b[63] ? 64'd0 - req.b : req.b;
         neg_in   = req.a[63] ^ req.b[63];
         acc_in   = 128'd0;
      end else if (busy_ff) begin
         if (phase_ff < 3'd4) begin
            acc_in   = acc_ff + pp_ext;
            phase_in = phase_ff + 3'd1;
         end else if (phase_ff == 3'd4) begin
            acc_in   = neg_ff ? 128'd0 - acc_ff : acc_ff;
            phase_in = phase_ff + 3'd1;
         end else begin
            res_in  = fits ? acc_ff[FRAC_BITS+63:FRAC_BITS]
                           : (acc_ff[127] ? pdvcu_pkg::SMIN : pdvcu_pkg::SMAX);
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 3'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

`default_nettype wire

FILE: rtl/pdvcu_div.sv
`default_nettype none

module pdvcu_div #(
   parameter int FRAC_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pdvcu_pkg::op_req_type req,
   output pdvcu_pkg::op_rsp_type rsp
);

   localparam int QW   = 64 + FRAC_BITS;
   localparam int CNTW = $clog2(QW + 1);

   logic            busy_ff, busy_in;
   logic            fin_ff, fin_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            neg_ff, neg_in;
   logic [63:0]     mb_ff, mb_in;
   logic [QW-1:0]   d_ff, d_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [63:0]     r_ff, r_in;
   logic [63:0]     res_ff, res_in;
   logic [63:0]     ma;
   logic [64:0]     rs;
   logic            ge;
   logic [63:0]     ql;

   assign ma = req.a[63] ? 64'd0 - req.a : req.a;
   assign rs = {r_ff, d_ff[QW-1]};
   assign ge = rs >= {1'b0, mb_ff};
   assign ql = q_ff[63:0];

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      mb_in   = mb_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      res_in  = res_ff;
      if (req.start) begin
         neg_in = req.a[63] ^ req.b[63];
         mb_in  = req.b[63] ? 64'd0 - req.b : req.b;
         if (req.b == 64'd0) begin
            // zero divisor saturates by the dividend sign
            res_in  = req.a[63] ? pdvcu_pkg::SMIN : pdvcu_pkg::SMAX;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = CNTW'(QW);
            d_in    = {ma, {FRAC_BITS{1'b0}}};
            q_in    = '0;
            r_in    = 64'd0;
         end
      end else if (busy_ff) begin
         // one restoring step per cycle
         r_in   = ge ? 64'(rs - {1'b0, mb_ff}) : rs[63:0];
         q_in   = {q_ff[QW-2:0], ge};
         d_in   = {d_ff[QW-2:0], 1'b0};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // quotient to signed result with saturation
         if (q_ff[QW-1:64] != '0) begin
            res_in = neg_ff ? pdvcu_pkg::SMIN : pdvcu_pkg::SMAX;
         end else if (!neg_ff) begin
            res_in = ql[63] ? pdvcu_pkg::SMAX : ql;
         end else begin
            res_in = (ql > pdvcu_pkg::SMIN) ? pdvcu_pkg::SMIN : 64'd0 - ql;
         end
         done_in = 1'b1;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mb_ff  <= mb_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

`default_nettype wire

FILE: rtl/pdvcu_checker.sv
`default_nettype none

`include "assert_macros.svh"

module pdvcu_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input pdvcu_pkg::pdvcu_rsp_type rsp_data
);

   // a stalled result keeps its value
   `PDVCU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // one point in work at a time
   `PDVCU_ASSERT_NEXT(a_one_point, clock, reset, req_valid && req_ready, !req_ready, "input ready right after a transaction")

   // a result never follows its point in the next cycle
   `PDVCU_ASSERT_SAME(a_no_early_rsp, clock, reset, $rose(rsp_valid), !$past(req_valid && req_ready), "result too early")

endmodule

bind pdv_cell_update_core pdvcu_checker u_pdvcu_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;

   localparam int ROW_MAX   = 1025;
   localparam int FRAC      = 40;
   localparam int WDOG_MAX  = 20000;
   localparam int SETTLE    = 20;
   localparam int HOLD_LONG = 3000;

   localparam logic signed [127:0] WIDE_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [127:0] WIDE_MIN = -128'sh8000_0000_0000_0000;

   // point flavors for directed stimulus
   localparam int PT_MIXED = 0;
   localparam int PT_ALL_MAX = 1;
   localparam int PT_ALL_MIN = 2;
   localparam int PT_ALL_ZERO = 3;
   localparam int PT_ZERO_DIV = 4;
   localparam int PT_BENIGN = 5;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   pdvcu_pkg::pdvcu_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   pdvcu_pkg::pdvcu_rsp_type rsp_data;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = pdvcu_pkg::CSR_TIME_STEP;
   logic [63:0]   csr_wdata = '0;

   pdv_cell_update_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the block state
   logic [63:0] line_mem [0:ROW_MAX*pdvcu_pkg::NVALS-1];
   logic [63:0] left_pt [0:pdvcu_pkg::NVALS-1];
   logic [63:0] diag_pt [0:pdvcu_pkg::NVALS-1];
   int          scan_col;
   logic        on_first_row;
   logic [62:0] dt;
   logic        half_step;
   logic [10:0] row_len_reg;

   pdvcu_pkg::pdvcu_rsp_type cell_results_q[$];
   int            mismatches = 0;
   int            burst_left = 0;
   int            hold_token = 0;

   // saturating arithmetic in Q23.40
   function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? pdvcu_pkg::SMIN : pdvcu_pkg::SMAX;
      return r;
   endfunction

   function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] r;
      r = a - b;
      if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? pdvcu_pkg::SMIN : pdvcu_pkg::SMAX;
      return r;
   endfunction

   function automatic logic [63:0] q_clamp(input logic signed [127:0] w);
      if (w > WIDE_MAX) return pdvcu_pkg::SMAX;
      if (w < WIDE_MIN) return pdvcu_pkg::SMIN;
      return w[63:0];
   endfunction

   function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
      logic signed [127:0] p;
      p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
      return q_clamp(p >>> FRAC);
   endfunction

   function automatic logic [63:0] q_div(input logic [63:0] a, input logic [63:0] b);
      logic signed [127:0] num, den;
      if (b == 64'd0) return a[63] ? pdvcu_pkg::SMIN : pdvcu_pkg::SMAX;
      num = $signed({{64{a[63]}}, a}) <<< FRAC;
      den = $signed({{64{b[63]}}, b});
      return q_clamp(num / den);
   endfunction

   // flux through one face
   function automatic logic [63:0] face_flux(input logic [63:0] area,
         input logic [63:0] o1, input logic [63:0] o2,
         input logic [63:0] n1, input logic [63:0] n2);
      logic [63:0] s, f;
      if (half_step) begin
         n1 = o1;
         n2 = o2;
      end
      s = q_add(q_add(q_add(o1, o2), n1), n2);
      f = q_mul(area, s);
      f = {{2{f[63]}}, f[63:2]};
      f = q_mul(f, {1'b0, dt});
      if (half_step) f = {f[63], f[63:1]};
      return f;
   endfunction

   // advance the shadow state by one point, queue a cell result if one is due
   task automatic update_cell(input pdvcu_pkg::pdvcu_req_type p);
      logic [63:0]   cur [0:pdvcu_pkg::NVALS-1];
      logic [63:0]   above [0:pdvcu_pkg::NVALS-1];
      logic [63:0]   lf, rf, bf, tf, tot, vr, rcp, ec;
      pdvcu_pkg::pdvcu_rsp_type r;
      int            len;
      len = int'(row_len_reg);
      if (len < 2) len = 2;
      if (len > ROW_MAX) len = ROW_MAX;
      if (p.frame_start) begin
         scan_col = 0;
         on_first_row = 1'b1;
      end
      if (scan_col >= len) begin
         scan_col = 0;
         on_first_row = 1'b0;
      end
      cur[pdvcu_pkg::P_XA] = p.x_face_area;
      cur[pdvcu_pkg::P_XV0] = p.x_vel_old;
      cur[pdvcu_pkg::P_XV1] = p.x_vel_new;
      cur[pdvcu_pkg::P_YA] = p.y_face_area;
      cur[pdvcu_pkg::P_YV0] = p.y_vel_old;
      cur[pdvcu_pkg::P_YV1] = p.y_vel_new;
      cur[pdvcu_pkg::P_VOL] = p.cell_volume;
      cur[pdvcu_pkg::P_PRE] = p.cell_pressure;
      cur[pdvcu_pkg::P_RHO] = p.density_old;
      cur[pdvcu_pkg::P_VIS] = p.cell_viscosity;
      cur[pdvcu_pkg::P_EN] = p.energy_old;
      for (int k = 0; k < pdvcu_pkg::NVALS; k++) begin
         above[k] = on_first_row ? 64'd0 : line_mem[scan_col*pdvcu_pkg::NVALS+k];
      end
      if (!on_first_row && scan_col >= 1) begin
         lf = face_flux(diag_pt[pdvcu_pkg::P_XA], diag_pt[pdvcu_pkg::P_XV0],
                        left_pt[pdvcu_pkg::P_XV0], diag_pt[pdvcu_pkg::P_XV1],
                        left_pt[pdvcu_pkg::P_XV1]);
         rf = face_flux(above[pdvcu_pkg::P_XA], above[pdvcu_pkg::P_XV0],
                        cur[pdvcu_pkg::P_XV0], above[pdvcu_pkg::P_XV1],
                        cur[pdvcu_pkg::P_XV1]);
         bf = face_flux(diag_pt[pdvcu_pkg::P_YA], diag_pt[pdvcu_pkg::P_YV0],
                        above[pdvcu_pkg::P_YV0], diag_pt[pdvcu_pkg::P_YV1],
                        above[pdvcu_pkg::P_YV1]);
         tf = face_flux(left_pt[pdvcu_pkg::P_YA], left_pt[pdvcu_pkg::P_YV0],
                        cur[pdvcu_pkg::P_YV0], left_pt[pdvcu_pkg::P_YV1],
                        cur[pdvcu_pkg::P_YV1]);
         tot = q_sub(q_add(q_sub(rf, lf), tf), bf);
         vr = q_div(diag_pt[pdvcu_pkg::P_VOL], q_add(diag_pt[pdvcu_pkg::P_VOL], tot));
         rcp = q_div(64'd1 << FRAC, diag_pt[pdvcu_pkg::P_VOL]);
         ec = q_add(q_div(diag_pt[pdvcu_pkg::P_PRE], diag_pt[pdvcu_pkg::P_RHO]),
                    q_div(diag_pt[pdvcu_pkg::P_VIS], diag_pt[pdvcu_pkg::P_RHO]));
         ec = q_mul(q_mul(ec, tot), rcp);
         r.volume_ratio = vr;
         r.density_new = q_mul(diag_pt[pdvcu_pkg::P_RHO], vr);
         r.energy_new = q_sub(diag_pt[pdvcu_pkg::P_EN], ec);
         cell_results_q.push_back(r);
      end
      for (int k = 0; k < pdvcu_pkg::NVALS; k++) begin
         diag_pt[k] = above[k];
         left_pt[k] = cur[k];
         line_mem[scan_col*pdvcu_pkg::NVALS+k] = cur[k];
      end
      scan_col++;
      if (scan_col >= len) begin
         scan_col = 0;
         on_first_row = 1'b0;
      end
   endtask

   // random values
   function automatic logic [63:0] rnd_q();
      logic [63:0] m;
      case ($urandom_range(0, 19))
         0: m = {$urandom, $urandom};
         1: m = pdvcu_pkg::SMAX;
         2: m = pdvcu_pkg::SMIN;
         3: m = 64'd0;
         default: begin
            m = {$urandom, $urandom} & ((64'd1 << 43) - 1);
            if ($urandom_range(0, 1)) m = -m;
         end
      endcase
      return m;
   endfunction

   function automatic logic [63:0] rnd_pos();
      if ($urandom_range(0, 9) == 0) return rnd_q();
      return (64'd1 << 38) + ({$urandom, $urandom} & ((64'd1 << 42) - 1));
   endfunction

   function automatic pdvcu_pkg::pdvcu_req_type make_point(input logic fs, input int flavor);
      pdvcu_pkg::pdvcu_req_type p;
      p.frame_start = fs;
      p.x_face_area = rnd_q();
      p.x_vel_old = rnd_q();
      p.x_vel_new = rnd_q();
      p.y_face_area = rnd_q();
      p.y_vel_old = rnd_q();
      p.y_vel_new = rnd_q();
      p.cell_volume = rnd_pos();
      p.cell_pressure = rnd_q();
      p.density_old = rnd_pos();
      p.cell_viscosity = rnd_q();
      p.energy_old = rnd_q();
      case (flavor)
         PT_ALL_MAX: p = {fs, {pdvcu_pkg::NVALS{pdvcu_pkg::SMAX}}};
         PT_ALL_MIN: p = {fs, {pdvcu_pkg::NVALS{pdvcu_pkg::SMIN}}};
         PT_ALL_ZERO: p = {fs, {pdvcu_pkg::NVALS{64'd0}}};
         PT_ZERO_DIV: begin
            p.cell_volume = 64'd0;
            p.density_old = 64'd0;
         end
         PT_BENIGN: begin
            p.x_face_area = 64'd1 << 40;
            p.y_face_area = 64'd1 << 40;
            p.x_vel_old = 64'd3 << 36;
            p.y_vel_old = -(64'd5 << 35);
         end
         default: ;
      endcase
      return p;
   endfunction

   // one point over the request channel, predicted when it is taken
   task automatic send_point(input pdvcu_pkg::pdvcu_req_type p);
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_ready);
      update_cell(p);
   endtask

   // sender bursts with random gaps
   task automatic pace();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
   endtask

   // pause the sender until every cell result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (cell_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         pdvcu_pkg::CSR_TIME_STEP: dt = val[62:0];
         pdvcu_pkg::CSR_PREDICT: half_step = val[0];
         pdvcu_pkg::CSR_ROW_POINTS: row_len_reg = val[10:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic setup(input logic [63:0] step, input logic pm, input logic [63:0] rows);
      csr_write(pdvcu_pkg::CSR_TIME_STEP, step);
      csr_write(pdvcu_pkg::CSR_PREDICT, {$urandom, $urandom} & ~64'd1 | pm);
      csr_write(pdvcu_pkg::CSR_ROW_POINTS, rows);
   endtask

   task automatic send_run(input int n, input int flavor, input logic first_fs);
      for (int i = 0; i < n; i++) begin
         send_point(make_point(first_fs && i == 0, flavor));
         pace();
      end
   endtask

   // saturation, zero divisors and a row of three points
   task automatic test_extremes();
      setup(64'd1 << 36, 1'b0, 64'd3);
      send_point(make_point(1'b1, PT_ALL_MAX));
      send_point(make_point(1'b0, PT_ALL_MIN));
      send_point(make_point(1'b0, PT_ALL_ZERO));
      send_point(make_point(1'b0, PT_ZERO_DIV));
      send_point(make_point(1'b0, PT_ALL_MAX));
      send_point(make_point(1'b0, PT_ALL_MIN));
      send_point(make_point(1'b0, PT_ALL_ZERO));
      send_point(make_point(1'b0, PT_BENIGN));
      send_point(make_point(1'b0, PT_MIXED));
      drain();
   endtask

   // row length below the minimum acts as two points
   task automatic test_min_row();
      setup(64'd0, 1'b0, 64'd0);
      send_run(6, PT_BENIGN, 1'b1);
      drain();
   endtask

   // predictor half step at the largest time step
   task automatic test_predict();
      setup(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd3);
      send_run(6, PT_MIXED, 1'b1);
      drain();
   endtask

   // row shortened mid-row: counter past the end starts a new row
   task automatic test_row_shrink();
      setup(64'd1 << 33, 1'b0, 64'd4);
      send_run(7, PT_BENIGN, 1'b1);
      drain();
      csr_write(pdvcu_pkg::CSR_ROW_POINTS, 64'd2);
      send_run(4, PT_MIXED, 1'b0);
      drain();
   endtask

   // oversized row length keeps a long first row without wrapping
   task automatic test_long_row();
      setup(64'd1 << 34, 1'b0, 64'h7FF);
      send_run(300, PT_MIXED, 1'b1);
      drain();
   endtask

   // random phases, one of them under a long receiver hold-off
   task automatic test_random();
      logic [63:0] step;
      for (int ph = 0; ph < 5; ph++) begin
         step = {$urandom, $urandom} >> $urandom_range(20, 40);
         if ($urandom_range(0, 7) == 0) step = {$urandom, $urandom};
         setup(step, ph[0], ph == 4 ? 64'd40 : 64'(2 + $urandom_range(0, 10)));
         if (ph == 1) begin
            hold_token++;
            burst_left = 200;
         end
         for (int i = 0; i < 80; i++) begin
            send_point(make_point(i == 0 || $urandom_range(0, 59) == 0, PT_MIXED));
            pace();
         end
         drain();
      end
   endtask

   // receiver stalls on its own pattern, plus a long counted hold-off
   int hold_seen = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_LONG;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 400);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 3) != 0;
            default: rsp_ready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   // compare each cell result with the oldest prediction
   always @(posedge clock) begin
      pdvcu_pkg::pdvcu_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cell_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected cell result %h", rsp_data);
         end else begin
            e = cell_results_q.pop_front();
            if (rsp_data.volume_ratio !== e.volume_ratio ||
                rsp_data.density_new !== e.density_new ||
                rsp_data.energy_new !== e.energy_new) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch ratio exp %h act %h", e.volume_ratio,
                           rsp_data.volume_ratio);
                  $display("   density exp %h act %h", e.density_new, rsp_data.density_new);
                  $display("   energy exp %h act %h", e.energy_new, rsp_data.energy_new);
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WDOG_MAX) begin
         $display("FAIL pdv_cell_update_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int k = 0; k < pdvcu_pkg::NVALS; k++) begin
         left_pt[k] = '0;
         diag_pt[k] = '0;
      end
      scan_col = 0;
      on_first_row = 1'b1;
      dt = '0;
      half_step = 1'b0;
      row_len_reg = 11'd1025;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_min_row();
      test_predict();
      test_row_shrink();
      test_long_row();
      test_random();
      drain();
      if (mismatches == 0) begin
         $display("PASS pdv_cell_update_core");
      end else begin
         $display("FAIL pdv_cell_update_core");
      end
      $finish;
   end

endmodule

`default_nettype wire
